/* hw/rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the stereo distance panner
// Transaction payloads, register indexes and pow factor table generation.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int POS_WIDTH    = 20;
   localparam int SAMPLE_WIDTH = 16;
   localparam int MD_WIDTH     = 19;
   localparam int EX_WIDTH     = 16;
   localparam int GAIN_WIDTH   = 16;
   localparam int CSR_WIDTH    = (POS_WIDTH > MD_WIDTH) ? POS_WIDTH : MD_WIDTH;
   localparam int MAG_WIDTH    = 31;

   localparam logic [GAIN_WIDTH-1:0] ONE_Q15 = 16'h8000;
   localparam logic [MAG_WIDTH-1:0]  FAR_LIMIT = 31'h4000_0000;

   typedef enum logic [1:0] {
      REG_LISTENER_X    = 2'd0,
      REG_LISTENER_Y    = 2'd1,
      REG_MAX_DISTANCE  = 2'd2,
      REG_FALLOFF_EXP   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0]    source_x;
      logic signed [POS_WIDTH-1:0]    source_y;
      logic [GAIN_WIDTH-1:0]          sound_gain;
      logic signed [SAMPLE_WIDTH-1:0] sample_left;
      logic signed [SAMPLE_WIDTH-1:0] sample_right;
   } req_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]          gain_left;
      logic [GAIN_WIDTH-1:0]          gain_right;
      logic signed [SAMPLE_WIDTH-1:0] out_left;
      logic signed [SAMPLE_WIDTH-1:0] out_right;
   } rsp_type;

   typedef struct packed {
      logic [MAG_WIDTH-1:0]           adx;
      logic [MAG_WIDTH-1:0]           ady;
      logic                           dx_neg;
      logic [GAIN_WIDTH-1:0]          sound_gain;
      logic [MD_WIDTH-1:0]            max_distance;
      logic [EX_WIDTH-1:0]            falloff_exponent;
      logic signed [SAMPLE_WIDTH-1:0] sample_left;
      logic signed [SAMPLE_WIDTH-1:0] sample_right;
   } work_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      n = x;
      res = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-(j+1)) in Q30
   function automatic logic [MAG_WIDTH-1:0] pow_factor(input int j);
      logic [63:0] v;
      v = isqrt64(64'd1 << 59);
      for (int i = 1; i <= j; i++) begin
         v = isqrt64(v << 30);
      end
      return v[MAG_WIDTH-1:0];
   endfunction

endpackage

/* hw/rtl/spd_fifo.sv */
// ----------------------------------------------------------------------------
// spd_fifo: work queue between front and back
// Small register queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module spd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spd_pkg::work_type wdata,
   output logic              full,
   input  logic              pop,
   output spd_pkg::work_type rdata,
   output logic              empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   spd_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic wr, rd;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr    = push && !full;
   assign rd    = pop && !empty;
   assign rdata = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (rd) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

endmodule

/* hw/rtl/spd_front.sv */
// ----------------------------------------------------------------------------
// spd_front: configuration registers and item classification
// Forms the listener offset magnitudes, pan sign and clamped gain per item.
// ----------------------------------------------------------------------------
module spd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  spd_pkg::reg_index_type        csr_index,
   input  logic [spd_pkg::CSR_WIDTH-1:0] csr_wdata,
   input  spd_pkg::req_type              req_data,
   output spd_pkg::work_type             work
);

   localparam int PW = spd_pkg::POS_WIDTH;

   logic signed [PW-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [spd_pkg::MD_WIDTH-1:0] md_ff, md_in;
   logic [spd_pkg::EX_WIDTH-1:0] ex_ff, ex_in;
   logic signed [PW:0] dx, dy;
   logic [PW:0] mx, my;

   function automatic logic [spd_pkg::MAG_WIDTH-1:0] clamp_far(input logic [PW:0] m);
      logic [32:0] w;
      w = 33'(m);
      if (w > 33'(spd_pkg::FAR_LIMIT)) begin
         w = 33'(spd_pkg::FAR_LIMIT);
      end
      return w[spd_pkg::MAG_WIDTH-1:0];
   endfunction

   always_comb begin
      lx_in = lx_ff;
      ly_in = ly_ff;
      md_in = md_ff;
      ex_in = ex_ff;
      if (csr_we) begin
         case (csr_index)
            spd_pkg::REG_LISTENER_X:   lx_in = csr_wdata[PW-1:0];
            spd_pkg::REG_LISTENER_Y:   ly_in = csr_wdata[PW-1:0];
            spd_pkg::REG_MAX_DISTANCE: md_in = csr_wdata[spd_pkg::MD_WIDTH-1:0];
            spd_pkg::REG_FALLOFF_EXP:  ex_in = csr_wdata[spd_pkg::EX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff <= '0;
         ly_ff <= '0;
         md_ff <= 19'd16384;
         ex_ff <= 16'd4096;
      end else begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         md_ff <= md_in;
         ex_ff <= ex_in;
      end
   end

   always_comb begin
      dx = (PW+1)'(req_data.source_x) - (PW+1)'(lx_ff);
      dy = (PW+1)'(req_data.source_y) - (PW+1)'(ly_ff);
      mx = dx[PW] ? (PW+1)'(-dx) : (PW+1)'(dx);
      my = dy[PW] ? (PW+1)'(-dy) : (PW+1)'(dy);
      work.adx = clamp_far(mx);
      work.ady = clamp_far(my);
      work.dx_neg = dx[PW];
      work.sound_gain = (req_data.sound_gain > spd_pkg::ONE_Q15) ?
                        spd_pkg::ONE_Q15 : req_data.sound_gain;
      work.max_distance = (md_ff == '0) ? 19'd1 : md_ff;
      work.falloff_exponent = ex_ff;
      work.sample_left = req_data.sample_left;
      work.sample_right = req_data.sample_right;
   end

endmodule

/* hw/rtl/spd_back.sv */
// ----------------------------------------------------------------------------
// spd_back: distance, pan, falloff and gain pipeline
// Bit-per-stage square root and dividers, squaring log, factor product exp.
// ----------------------------------------------------------------------------
module spd_back (
   input  logic              clock,
   input  logic              reset,
   input  spd_pkg::work_type q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output spd_pkg::rsp_type  rsp_data
);

   localparam int SW     = spd_pkg::SAMPLE_WIDTH;
   localparam int ST_SQ  = 0;
   localparam int ST_SUM = 1;
   localparam int RT_N   = 31;
   localparam int ST_RT  = 2;
   localparam int ST_DV  = ST_RT + RT_N;
   localparam int DQ_N   = 15;
   localparam int ST_DQ  = ST_DV + 1;
   localparam int ST_NRM = ST_DQ + DQ_N;
   localparam int LG_N   = 16;
   localparam int ST_LG  = ST_NRM + 1;
   localparam int ST_LOG = ST_LG + LG_N;
   localparam int ST_PWR = ST_LOG + 1;
   localparam int EX_N   = 16;
   localparam int ST_EX  = ST_PWR + 1;
   localparam int ST_FIN = ST_EX + EX_N;
   localparam int ST_CMB = ST_FIN + 1;
   localparam int ST_GN  = ST_CMB + 1;
   localparam int ST_OUT = ST_GN + 1;
   localparam int N_STG  = ST_OUT + 1;

   typedef struct packed {
      logic signed [SW-1:0] sl;
      logic signed [SW-1:0] sr;
      logic [15:0] sg;
      logic [18:0] md;
      logic [15:0] ex;
      logic        dx_neg;
      logic [30:0] adx;
      logic [61:0] sqx;
      logic [61:0] sqy;
      logic [61:0] rn;
      logic [61:0] rr;
      logic [19:0] prem;
      logic [14:0] pq;
      logic        psat;
      logic [19:0] brem;
      logic [14:0] bq;
      logic        bzero;
      logic        bfull;
      logic [15:0] pan;
      logic        one;
      logic        zero;
      logic [30:0] m;
      logic [3:0]  k;
      logic [15:0] f;
      logic [19:0] lgv;
      logic [23:0] p;
      logic [30:0] r;
      logic [15:0] dg;
      logic [15:0] lp;
      logic [15:0] rp;
      logic [15:0] comb;
      logic [15:0] gl;
      logic [15:0] gr;
      logic signed [SW-1:0] ol;
      logic signed [SW-1:0] orr;
   } pipe_type;

   pipe_type pipe_ff [N_STG];
   pipe_type pipe_in [N_STG];
   logic [N_STG-1:0] vld_ff;
   logic en;

   function automatic logic signed [SW-1:0] scale(input logic signed [SW-1:0] s,
                                                   input logic [15:0] g);
      logic signed [SW+17:0] sx;
      logic signed [SW+17:0] gx;
      logic signed [SW+17:0] t;
      logic signed [SW+2:0]  q;
      sx = (SW+18)'(s);
      gx = (SW+18)'($signed({1'b0, g}));
      t = sx * gx + (SW+18)'(16384);
      q = (SW+3)'(t >>> 15);
      if (q > (SW+3)'((1 << (SW - 1)) - 1)) begin
         q = (SW+3)'((1 << (SW - 1)) - 1);
      end else if (q < -(SW+3)'(1 << (SW - 1))) begin
         q = -(SW+3)'(1 << (SW - 1));
      end
      return q[SW-1:0];
   endfunction

   assign en    = !vld_ff[ST_OUT] || rsp_pop;
   assign q_pop = en && !q_empty;

   always_comb begin
      pipe_in[ST_SQ]        = '0;
      pipe_in[ST_SQ].sl     = q_data.sample_left;
      pipe_in[ST_SQ].sr     = q_data.sample_right;
      pipe_in[ST_SQ].sg     = q_data.sound_gain;
      pipe_in[ST_SQ].md     = q_data.max_distance;
      pipe_in[ST_SQ].ex     = q_data.falloff_exponent;
      pipe_in[ST_SQ].dx_neg = q_data.dx_neg;
      pipe_in[ST_SQ].adx    = q_data.adx;
      pipe_in[ST_SQ].sqx    = 62'(q_data.adx) * 62'(q_data.adx);
      pipe_in[ST_SQ].sqy    = 62'(q_data.ady) * 62'(q_data.ady);
   end

   always_comb begin
      pipe_in[ST_SUM]    = pipe_ff[ST_SUM-1];
      pipe_in[ST_SUM].rn = pipe_ff[ST_SUM-1].sqx + pipe_ff[ST_SUM-1].sqy;
      pipe_in[ST_SUM].rr = '0;
   end

   for (genvar t = 0; t < RT_N; t++) begin : g_rt
      localparam logic [61:0] BIT_V = 62'(1) << (60 - 2 * t);
      logic [61:0] trial;
      always_comb begin
         pipe_in[ST_RT+t] = pipe_ff[ST_RT+t-1];
         trial = pipe_ff[ST_RT+t-1].rr + BIT_V;
         if (pipe_ff[ST_RT+t-1].rn >= trial) begin
            pipe_in[ST_RT+t].rn = pipe_ff[ST_RT+t-1].rn - trial;
            pipe_in[ST_RT+t].rr = (pipe_ff[ST_RT+t-1].rr >> 1) + BIT_V;
         end else begin
            pipe_in[ST_RT+t].rr = pipe_ff[ST_RT+t-1].rr >> 1;
         end
      end
   end

   // zero distance gives a base of exactly one, which the 15-bit quotient cannot hold
   always_comb begin
      pipe_in[ST_DV]       = pipe_ff[ST_DV-1];
      pipe_in[ST_DV].psat  = pipe_ff[ST_DV-1].adx >= 31'(pipe_ff[ST_DV-1].md);
      pipe_in[ST_DV].prem  = pipe_in[ST_DV].psat ? '0 : 20'(pipe_ff[ST_DV-1].adx[18:0]);
      pipe_in[ST_DV].bzero = pipe_ff[ST_DV-1].rr[30:0] >= 31'(pipe_ff[ST_DV-1].md);
      pipe_in[ST_DV].bfull = (pipe_ff[ST_DV-1].rr[30:0] == '0);
      pipe_in[ST_DV].brem  = pipe_in[ST_DV].bzero ? '0 :
                             20'(pipe_ff[ST_DV-1].md - pipe_ff[ST_DV-1].rr[18:0]);
      pipe_in[ST_DV].pq    = '0;
      pipe_in[ST_DV].bq    = '0;
   end

   for (genvar j = 0; j < DQ_N; j++) begin : g_dq
      logic [19:0] pt, bt, den;
      always_comb begin
         pipe_in[ST_DQ+j] = pipe_ff[ST_DQ+j-1];
         den = 20'(pipe_ff[ST_DQ+j-1].md);
         pt = {pipe_ff[ST_DQ+j-1].prem[18:0], 1'b0};
         bt = {pipe_ff[ST_DQ+j-1].brem[18:0], 1'b0};
         if (pt >= den) begin
            pipe_in[ST_DQ+j].prem = pt - den;
            pipe_in[ST_DQ+j].pq = {pipe_ff[ST_DQ+j-1].pq[13:0], 1'b1};
         end else begin
            pipe_in[ST_DQ+j].prem = pt;
            pipe_in[ST_DQ+j].pq = {pipe_ff[ST_DQ+j-1].pq[13:0], 1'b0};
         end
         if (bt >= den) begin
            pipe_in[ST_DQ+j].brem = bt - den;
            pipe_in[ST_DQ+j].bq = {pipe_ff[ST_DQ+j-1].bq[13:0], 1'b1};
         end else begin
            pipe_in[ST_DQ+j].brem = bt;
            pipe_in[ST_DQ+j].bq = {pipe_ff[ST_DQ+j-1].bq[13:0], 1'b0};
         end
      end
   end

   logic [14:0] nrm_base;
   logic [3:0]  nrm_msb;
   always_comb begin
      pipe_in[ST_NRM] = pipe_ff[ST_NRM-1];
      pipe_in[ST_NRM].pan = pipe_ff[ST_NRM-1].psat ? spd_pkg::ONE_Q15 :
                            16'(pipe_ff[ST_NRM-1].pq);
      nrm_base = pipe_ff[ST_NRM-1].bzero ? '0 : pipe_ff[ST_NRM-1].bq;
      nrm_msb = '0;
      for (int i = 0; i < 15; i++) begin
         if (nrm_base[i]) begin
            nrm_msb = 4'(i);
         end
      end
      pipe_in[ST_NRM].one  = (pipe_ff[ST_NRM-1].ex == '0) || pipe_ff[ST_NRM-1].bfull;
      pipe_in[ST_NRM].zero = (nrm_base == '0);
      pipe_in[ST_NRM].k    = 4'd15 - nrm_msb;
      pipe_in[ST_NRM].m    = 31'(nrm_base) << (5'd30 - 5'(nrm_msb));
      pipe_in[ST_NRM].f    = '0;
   end

   for (genvar i = 0; i < LG_N; i++) begin : g_lg
      logic [61:0] sq;
      logic [31:0] t32;
      always_comb begin
         pipe_in[ST_LG+i] = pipe_ff[ST_LG+i-1];
         sq = 62'(pipe_ff[ST_LG+i-1].m) * 62'(pipe_ff[ST_LG+i-1].m);
         t32 = sq[61:30];
         pipe_in[ST_LG+i].f = {pipe_ff[ST_LG+i-1].f[14:0], t32[31]};
         pipe_in[ST_LG+i].m = t32[31] ? t32[31:1] : t32[30:0];
      end
   end

   always_comb begin
      pipe_in[ST_LOG] = pipe_ff[ST_LOG-1];
      pipe_in[ST_LOG].lgv = {pipe_ff[ST_LOG-1].k, 16'h0000} - 20'(pipe_ff[ST_LOG-1].f);
   end

   logic [35:0] pwr_prod;
   always_comb begin
      pipe_in[ST_PWR] = pipe_ff[ST_PWR-1];
      pwr_prod = 36'(pipe_ff[ST_PWR-1].lgv) * 36'(pipe_ff[ST_PWR-1].ex) + 36'd2048;
      pipe_in[ST_PWR].p = pwr_prod[35:12];
      pipe_in[ST_PWR].zero = pipe_ff[ST_PWR-1].zero || (pwr_prod[35:32] != '0);
      pipe_in[ST_PWR].r = spd_pkg::FAR_LIMIT;
   end

   for (genvar i = 0; i < EX_N; i++) begin : g_ex
      localparam logic [30:0] FACTOR = spd_pkg::pow_factor(i);
      logic [61:0] prod;
      always_comb begin
         pipe_in[ST_EX+i] = pipe_ff[ST_EX+i-1];
         prod = 62'(pipe_ff[ST_EX+i-1].r) * 62'(FACTOR) + 62'(32'h2000_0000);
         if (pipe_ff[ST_EX+i-1].p[15-i]) begin
            pipe_in[ST_EX+i].r = prod[60:30];
         end
      end
   end

   logic [4:0]  fin_s;
   logic [31:0] fin_rnd;
   logic [31:0] fin_dg;
   always_comb begin
      pipe_in[ST_FIN] = pipe_ff[ST_FIN-1];
      fin_s = 5'd15 + 5'(pipe_ff[ST_FIN-1].p[19:16]);
      fin_rnd = 32'(pipe_ff[ST_FIN-1].r) + (32'd1 << (fin_s - 5'd1));
      fin_dg = fin_rnd >> fin_s;
      if (pipe_ff[ST_FIN-1].one) begin
         pipe_in[ST_FIN].dg = spd_pkg::ONE_Q15;
      end else if (pipe_ff[ST_FIN-1].zero) begin
         pipe_in[ST_FIN].dg = '0;
      end else begin
         pipe_in[ST_FIN].dg = fin_dg[15:0];
      end
   end

   logic [31:0] cmb_prod;
   always_comb begin
      pipe_in[ST_CMB] = pipe_ff[ST_CMB-1];
      cmb_prod = 32'(pipe_ff[ST_CMB-1].dg) * 32'(pipe_ff[ST_CMB-1].sg) + 32'd16384;
      pipe_in[ST_CMB].comb = cmb_prod[30:15];
      if (pipe_ff[ST_CMB-1].dx_neg) begin
         pipe_in[ST_CMB].lp = spd_pkg::ONE_Q15;
         pipe_in[ST_CMB].rp = spd_pkg::ONE_Q15 - pipe_ff[ST_CMB-1].pan;
      end else begin
         pipe_in[ST_CMB].lp = spd_pkg::ONE_Q15 - pipe_ff[ST_CMB-1].pan;
         pipe_in[ST_CMB].rp = spd_pkg::ONE_Q15;
      end
   end

   logic [31:0] gn_l, gn_r;
   always_comb begin
      pipe_in[ST_GN] = pipe_ff[ST_GN-1];
      gn_l = 32'(pipe_ff[ST_GN-1].lp) * 32'(pipe_ff[ST_GN-1].comb) + 32'd16384;
      gn_r = 32'(pipe_ff[ST_GN-1].rp) * 32'(pipe_ff[ST_GN-1].comb) + 32'd16384;
      pipe_in[ST_GN].gl = gn_l[30:15];
      pipe_in[ST_GN].gr = gn_r[30:15];
   end

   always_comb begin
      pipe_in[ST_OUT] = pipe_ff[ST_OUT-1];
      pipe_in[ST_OUT].ol = scale(pipe_ff[ST_OUT-1].sl, pipe_ff[ST_OUT-1].gl);
      pipe_in[ST_OUT].orr = scale(pipe_ff[ST_OUT-1].sr, pipe_ff[ST_OUT-1].gr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N_STG-2:0], !q_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_empty           = !vld_ff[ST_OUT];
   assign rsp_data.gain_left  = pipe_ff[ST_OUT].gl;
   assign rsp_data.gain_right = pipe_ff[ST_OUT].gr;
   assign rsp_data.out_left   = pipe_ff[ST_OUT].ol;
   assign rsp_data.out_right  = pipe_ff[ST_OUT].orr;

   a_dg_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_FIN] |-> pipe_ff[ST_FIN].dg <= spd_pkg::ONE_Q15)
      else $error("distance gain above unity");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT] |-> (pipe_ff[ST_OUT].gl <= spd_pkg::ONE_Q15 &&
                          pipe_ff[ST_OUT].gr <= spd_pkg::ONE_Q15))
      else $error("channel gain above unity");

endmodule

/* hw/rtl/stereo_distance_panner_core.sv */
// ----------------------------------------------------------------------------
// stereo_distance_panner_core: positional stereo panner with distance falloff
// Linear pan law plus power-law distance attenuation on one sample pair.
// ----------------------------------------------------------------------------
//  channel   ports                           transaction
//  request   req_push/req_full/req_data      source position, gain, samples
//  response  rsp_empty/rsp_pop/rsp_data      channel gains, scaled samples
//  csr       csr_we/csr_index/csr_wdata      listener, max distance, falloff
//
//  One transaction per clock sustained while responses are popped; the back
//  pipeline behind the work queue holds the bit-per-stage square root (31),
//  dividers (15), log (16) and exp (16) stages.
//  Synchronous reset clears control only; csr registers take reset values.
//  A held response freezes the back pipeline; the queue absorbs the front.
// ----------------------------------------------------------------------------
module stereo_distance_panner_core #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  spd_pkg::req_type              req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output spd_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  spd_pkg::reg_index_type        csr_index,
   input  logic [spd_pkg::CSR_WIDTH-1:0] csr_wdata
);

   spd_pkg::work_type work, q_data;
   logic q_empty, q_pop;

   spd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .work      (work)
   );

   spd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (work),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

   spd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response not empty after reset");

endmodule

/* tb/tb_stereo_distance_panner_core.sv */
// ----------------------------------------------------------------------------
// tb_stereo_distance_panner_core: self-checking bench for the distance panner
// Drives source positions and sample pairs through the queue ports, predicts
// channel gains and scaled samples in fixed point, and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stereo_distance_panner_core;

   localparam int DRAIN_CYCLES = 200;
   localparam int STALL_LIMIT  = 5000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   spd_pkg::req_type              req_data = '0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   spd_pkg::rsp_type              rsp_data;
   logic                          csr_we = 1'b0;
   spd_pkg::reg_index_type        csr_index = spd_pkg::REG_LISTENER_X;
   logic [spd_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   stereo_distance_panner_core dut (.*);

   always #1 clock = ~clock;

   longint             lis_x, lis_y;
   longint             max_dist, falloff;
   longint             factor_q30 [16];
   spd_pkg::rsp_type   expected_q [$];
   int                 error_count = 0;
   int                 item_count = 0;
   int                 result_count = 0;
   int                 idle_cycles = 0;
   bit                 hold_off = 1'b0;
   bit                 mute_idle = 1'b0;

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint falloff_pow(longint base, longint ex);
      longint unsigned m, f, lg, p, ip, fp, r;
      int k, s;
      if (ex == 0) return 32768;
      if (base == 0) return 0;
      if (base >= 32768) return 32768;
      m = base << 15;
      k = 0;
      f = 0;
      r = 64'd1 << 30;
      while (m < (64'd1 << 30)) begin
         m <<= 1;
         k++;
      end
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         f <<= 1;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            f |= 1;
         end
      end
      lg = k * 65536 - f;
      p = (lg * ex + 2048) >> 12;
      ip = p >> 16;
      fp = p & 16'hFFFF;
      if (ip >= 16) return 0;
      for (int i = 0; i < 16; i++)
         if (fp[15-i]) r = (r * factor_q30[i] + (64'd1 << 29)) >> 30;
      s = 15 + ip;
      return longint'((r + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic longint scale_sample(longint smp, longint g);
      longint t, q;
      t = smp * g + 16384;
      q = (t >= 0) ? t / 32768 : -((-t + 32767) / 32768);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic longint clamp_far(longint d);
      if (d > (64'sd1 << 30)) return 64'sd1 << 30;
      if (d < -(64'sd1 << 30)) return -(64'sd1 << 30);
      return d;
   endfunction

   function automatic spd_pkg::rsp_type pan_item(spd_pkg::req_type r);
      spd_pkg::rsp_type o;
      longint dx, dy, sg, md, span, pan, base, dg, comb, lg, rg, gl, gr, ol, orr;
      dx = clamp_far(longint'(r.source_x) - lis_x);
      dy = clamp_far(longint'(r.source_y) - lis_y);
      sg = r.sound_gain;
      if (sg > 32768) sg = 32768;
      md = (max_dist == 0) ? 1 : max_dist;
      span = int_sqrt(dx * dx + dy * dy);
      pan = (dx * 32768) / md;
      if (pan > 32768) pan = 32768;
      if (pan < -32768) pan = -32768;
      base = (span >= md) ? 0 : ((md - span) << 15) / md;
      dg = falloff_pow(base, falloff);
      lg = 32768;
      rg = 32768;
      if (pan < 0) rg = 32768 + pan;
      else lg = 32768 - pan;
      comb = (dg * sg + 16384) >> 15;
      gl = (lg * comb + 16384) >> 15;
      gr = (rg * comb + 16384) >> 15;
      ol = scale_sample(r.sample_left, gl);
      orr = scale_sample(r.sample_right, gr);
      o.gain_left = gl[15:0];
      o.gain_right = gr[15:0];
      o.out_left = ol[spd_pkg::SAMPLE_WIDTH-1:0];
      o.out_right = orr[spd_pkg::SAMPLE_WIDTH-1:0];
      return o;
   endfunction

   function automatic int short_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
   endfunction

   task automatic write_reg(spd_pkg::reg_index_type idx, longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[spd_pkg::CSR_WIDTH-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         spd_pkg::REG_LISTENER_X:
            lis_x = longint'($signed(value[spd_pkg::POS_WIDTH-1:0]));
         spd_pkg::REG_LISTENER_Y:
            lis_y = longint'($signed(value[spd_pkg::POS_WIDTH-1:0]));
         spd_pkg::REG_MAX_DISTANCE: max_dist = value[spd_pkg::MD_WIDTH-1:0];
         default:                   falloff = value[spd_pkg::EX_WIDTH-1:0];
      endcase
   endtask

   task automatic settle();
      req_push <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic push_item(spd_pkg::req_type r, int gap);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      expected_q = {expected_q, pan_item(r)};
      item_count++;
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic spd_pkg::req_type rand_item(int reach);
      spd_pkg::req_type r;
      longint px, py;
      logic [31:0] u;
      px = lis_x + longint'($urandom_range(0, 2 * reach)) - reach;
      py = lis_y + longint'($urandom_range(0, 2 * reach)) - reach;
      r.source_x = px[spd_pkg::POS_WIDTH-1:0];
      r.source_y = py[spd_pkg::POS_WIDTH-1:0];
      if ($urandom_range(0, 9) == 0) begin
         u = $urandom;
         r.source_x = u[spd_pkg::POS_WIDTH-1:0];
         u = $urandom;
         r.source_y = u[spd_pkg::POS_WIDTH-1:0];
      end
      u = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32768);
      r.sound_gain = u[spd_pkg::GAIN_WIDTH-1:0];
      u = $urandom;
      r.sample_left = u[spd_pkg::SAMPLE_WIDTH-1:0];
      u = $urandom;
      r.sample_right = u[spd_pkg::SAMPLE_WIDTH-1:0];
      return r;
   endfunction

   function automatic spd_pkg::req_type make_item(longint sx, longint sy, longint g,
                                                  longint sl, longint sr);
      spd_pkg::req_type r;
      r.source_x = sx[spd_pkg::POS_WIDTH-1:0];
      r.source_y = sy[spd_pkg::POS_WIDTH-1:0];
      r.sound_gain = g[spd_pkg::GAIN_WIDTH-1:0];
      r.sample_left = sl[spd_pkg::SAMPLE_WIDTH-1:0];
      r.sample_right = sr[spd_pkg::SAMPLE_WIDTH-1:0];
      return r;
   endfunction

   task automatic test_directed();
      push_item(make_item(0, 0, 32768, 32767, -32768), 0);
      push_item(make_item(0, 0, 65535, -32768, 32767), 0);
      push_item(make_item(524287, 0, 32768, 32767, 32767), 1);
      push_item(make_item(-524288, 0, 32768, -32768, -32768), 0);
      push_item(make_item(8000, 0, 32768, 20000, 20000), 0);
      push_item(make_item(-8000, 6000, 16384, 20000, -20000), 2);
      push_item(make_item(0, 16384, 32768, 1000, 1000), 0);
      push_item(make_item(100, 100, 0, 32767, 32767), 0);
      push_item(make_item(-524288, -524288, 32768, 1, -1), 0);
      push_item(make_item(524287, 524287, 40000, 5, 5), 0);
      push_item(make_item(3, -3, 1, -1, 1), 0);
      settle();
      write_reg(spd_pkg::REG_MAX_DISTANCE, 0);
      push_item(make_item(0, 0, 32768, 12345, -12345), 0);
      push_item(make_item(1, 0, 32768, 12345, -12345), 0);
      push_item(make_item(-1, 0, 32768, 12345, -12345), 0);
      settle();
      write_reg(spd_pkg::REG_MAX_DISTANCE, 524287);
      write_reg(spd_pkg::REG_FALLOFF_EXP, 0);
      write_reg(spd_pkg::REG_LISTENER_X, -524288);
      write_reg(spd_pkg::REG_LISTENER_Y, 524287);
      push_item(make_item(524287, -524288, 32768, 32767, 32767), 0);
      push_item(make_item(-524288, 524287, 32768, 32767, 32767), 0);
      push_item(make_item(0, 0, 32768, -32768, 32767), 0);
      settle();
   endtask

   task automatic test_random(int count);
      longint ex_set [6] = '{0, 1, 4096, 8192, 2048, 65535};
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(spd_pkg::REG_LISTENER_X, $urandom_range(0, 1048575));
         write_reg(spd_pkg::REG_LISTENER_Y, ($urandom_range(0, 1) != 0) ? 0 : $urandom);
         write_reg(spd_pkg::REG_MAX_DISTANCE,
                   (ph == 5) ? 1 : $urandom_range(1, 1 << (9 + 2 * ph)));
         write_reg(spd_pkg::REG_FALLOFF_EXP,
                   ex_set[ph] + ((ph == 3) ? $urandom_range(0, 9000) : 0));
         for (int i = 0; i < count / 6; i++)
            push_item(rand_item(int'(max_dist) + 4), short_gap());
         settle();
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 150; i++) push_item(rand_item(int'(max_dist)), 0);
      req_push <= 1'b0;
      wait (hold_off == 1'b0);
      settle();
   endtask

   task automatic test_quiet_receiver();
      mute_idle = 1'b1;
      for (int i = 0; i < 20; i++) push_item(rand_item(int'(max_dist)), 0);
      req_push <= 1'b0;
      settle();
      mute_idle = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_off) begin
         rsp_pop <= 1'b0;
         repeat (300) @(negedge clock);
         hold_off <= 1'b0;
      end else if (mute_idle || $urandom_range(0, 2) != 0) begin
         rsp_pop <= 1'b1;
      end else begin
         rsp_pop <= 1'b0;
         repeat (short_gap()) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      spd_pkg::rsp_type want;
      if (!reset && !rsp_empty && rsp_pop) begin
         result_count++;
         if (expected_q.size() == 0) begin
            $error("result without pending transaction");
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.gain_left !== want.gain_left) begin
               $error("gain_left exp %0d got %0d", want.gain_left, rsp_data.gain_left);
               error_count++;
            end
            if (rsp_data.gain_right !== want.gain_right) begin
               $error("gain_right exp %0d got %0d", want.gain_right, rsp_data.gain_right);
               error_count++;
            end
            if (rsp_data.out_left !== want.out_left) begin
               $error("out_left exp %0d got %0d", want.out_left, rsp_data.out_left);
               error_count++;
            end
            if (rsp_data.out_right !== want.out_right) begin
               $error("out_right exp %0d got %0d", want.out_right, rsp_data.out_right);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb_stereo_distance_panner_core: FAIL");
         $finish;
      end
   end

   initial begin
      factor_q30[0] = int_sqrt(64'd1 << 59);
      for (int j = 1; j < 16; j++) factor_q30[j] = int_sqrt(factor_q30[j-1] << 30);
      lis_x = 0;
      lis_y = 0;
      max_dist = 16384;
      falloff = 4096;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_random(210);
      test_quiet_receiver();
      $display("covered %0d transactions, %0d results: extremes, clamps, falloff range,",
               item_count, result_count);
      $display("zero max distance, long receiver stall and full-queue input stall");
      if (error_count == 0) begin
         $display("tb_stereo_distance_panner_core: PASS");
      end else begin
         $display("tb_stereo_distance_panner_core: FAIL");
      end
      $finish;
   end

endmodule
